// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the parser rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== hw/rtl/spc_pkg.sv =====
// types and constants of the sysex parameter change parser
package spc_pkg;

    localparam logic [7:0] MAKER_0        = 8'h00;
    localparam logic [7:0] MAKER_1        = 8'h20;
    localparam logic [7:0] MAKER_2        = 8'h32;
    localparam logic [7:0] APPARATUS_CODE = 8'h0B;
    localparam logic [7:0] FUNCTION_CODE  = 8'h20;

    localparam int HEADER_LEN = 7;
    localparam int HIGH_SHIFT = 7;
    localparam int BYTE_W     = 8;
    localparam int RAW_W      = 15;
    localparam int HPOS_W     = 3;
    localparam int GPOS_W     = 2;

    // result queue; a byte is taken only while at least two slots are free for its results
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_SHORT     = 3'd1,
        STATUS_BAD_MAKER = 3'd2,
        STATUS_BAD_FUNC  = 3'd3,
        STATUS_TRUNCATED = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        GRP_MODULE = 2'd0,
        GRP_PARAM  = 2'd1,
        GRP_HIGH   = 2'd2,
        GRP_LOW    = 2'd3
    } group_pos_t;

    typedef struct packed {
        logic                 is_status;
        logic [BYTE_W-1:0]    module_id;
        logic [BYTE_W-1:0]    param_id;
        logic [RAW_W-1:0]     raw_value;
        status_t              frame_status;
        logic                 last_result;
    } result_t;

endpackage

// ===== hw/rtl/spc_if.sv =====
// valid/ready channels for body bytes and parser results
interface spc_body_if;
    logic       valid;
    logic       ready;
    logic [7:0] body_byte;
    logic       end_of_message;

    modport source (output valid, output body_byte, output end_of_message, input ready);
    modport sink   (input valid, input body_byte, input end_of_message, output ready);
endinterface

interface spc_result_if;
    logic        valid;
    logic        ready;
    logic        is_status;
    logic [7:0]  module_id;
    logic [7:0]  param_id;
    logic [14:0] raw_value;
    logic [2:0]  frame_status;
    logic        last_result;

    modport source (output valid, output is_status, output module_id, output param_id,
                    output raw_value, output frame_status, output last_result,
                    input ready);
    modport sink   (input valid, input is_status, input module_id, input param_id,
                    input raw_value, input frame_status, input last_result,
                    output ready);
endinterface

// ===== hw/rtl/sysex_param_change_parser.sv =====
// Parser for the body of a sysex parameter change message. One body byte is
// taken per cycle while body.ready is high; the header check and group
// assembly for a byte finish in the cycle it is transferred; its results go
// into a four-entry result queue that drains one result per cycle while
// result.ready is high. A byte gives at most two results (a change and, on
// the last byte, the frame status), so body.ready is high whenever at least
// two queue slots are free; with the result side always ready the block
// sustains one byte per cycle. A byte that completes a group and ends the
// message pushes both results. Changes of a frame are delivered as their
// groups complete; the consumer keeps them only if the frame's status is ok.
`include "assert_macros.svh"

module sysex_param_change_parser
    import spc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    spc_body_if.sink      body,
    spc_result_if.source  result
);

    logic [HPOS_W-1:0] header_pos_reg, header_pos_next;
    status_t           reject_reg, reject_next;
    logic [BYTE_W-1:0] changes_left_reg, changes_left_next;
    group_pos_t        group_pos_reg, group_pos_next;
    logic [BYTE_W-1:0] held_module_reg, held_module_next;
    logic [BYTE_W-1:0] held_param_reg, held_param_next;
    logic [BYTE_W-1:0] held_high_reg, held_high_next;
    logic              groups_done_reg, groups_done_next;

    result_t           queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    logic              accept;
    logic              pop;
    logic              emit_change;
    logic              emit_status;
    result_t           change_res;
    result_t           status_res;
    logic [1:0]        push_n;
    logic [BYTE_W-1:0] b;

    assign b      = body.body_byte;
    assign accept = body.valid && body.ready;
    assign pop    = result.valid && result.ready;

    assign body.ready = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));

    // per-byte state update
    always_comb
    begin
        header_pos_next   = header_pos_reg;
        reject_next       = reject_reg;
        changes_left_next = changes_left_reg;
        group_pos_next    = group_pos_reg;
        held_module_next  = held_module_reg;
        held_param_next   = held_param_reg;
        held_high_next    = held_high_reg;
        groups_done_next  = groups_done_reg;
        emit_change       = 1'b0;
        emit_status       = 1'b0;

        if (accept)
        begin
            if (header_pos_reg < HPOS_W'(HEADER_LEN))
            begin
                if (reject_reg == STATUS_OK)
                begin
                    priority if ((header_pos_reg == 3'd0 && b != MAKER_0) ||
                                 (header_pos_reg == 3'd1 && b != MAKER_1) ||
                                 (header_pos_reg == 3'd2 && b != MAKER_2))
                    begin
                        reject_next = STATUS_BAD_MAKER;
                    end
                    else if ((header_pos_reg == 3'd4 && b != APPARATUS_CODE) ||
                             (header_pos_reg == 3'd5 && b != FUNCTION_CODE))
                    begin
                        reject_next = STATUS_BAD_FUNC;
                    end
                    else if (header_pos_reg == 3'd6)
                    begin
                        changes_left_next = b;
                        groups_done_next  = (b == '0);
                    end
                    else
                    begin
                        reject_next = reject_reg;
                    end
                end
                header_pos_next = header_pos_reg + 1'b1;
            end
            else if (reject_reg == STATUS_OK && !groups_done_reg && changes_left_reg != '0)
            begin
                unique case (group_pos_reg)
                    GRP_MODULE: held_module_next = b;
                    GRP_PARAM:  held_param_next  = b;
                    GRP_HIGH:   held_high_next   = b;
                    GRP_LOW:
                    begin
                        emit_change       = 1'b1;
                        changes_left_next = changes_left_reg - 1'b1;
                        if (changes_left_reg == 8'd1)
                        begin
                            groups_done_next = 1'b1;
                        end
                    end
                    default: held_high_next = held_high_reg;
                endcase
                group_pos_next = group_pos_t'(group_pos_reg + 1'b1);
            end

            if (body.end_of_message)
            begin
                emit_status       = 1'b1;
                header_pos_next   = '0;
                reject_next       = STATUS_OK;
                changes_left_next = '0;
                group_pos_next    = GRP_MODULE;
                held_module_next  = '0;
                held_param_next   = '0;
                held_high_next    = '0;
                groups_done_next  = 1'b0;
            end
        end
    end

    // result contents, status judged on the state after this byte
    always_comb
    begin
        change_res              = '0;
        change_res.module_id    = held_module_reg;
        change_res.param_id     = held_param_reg;
        change_res.raw_value    = ({held_high_reg, 7'b0} | {7'b0, b});
        change_res.frame_status = STATUS_OK;
        change_res.last_result  = !body.end_of_message;

        status_res              = '0;
        status_res.is_status    = 1'b1;
        status_res.last_result  = 1'b1;
        if (header_pos_reg < HPOS_W'(HEADER_LEN - 1))
        begin
            status_res.frame_status = STATUS_SHORT;
        end
        else if (header_pos_reg == HPOS_W'(HEADER_LEN - 1))
        begin
            // seventh byte arrives with the end flag: header complete
            if (reject_reg != STATUS_OK)
            begin
                status_res.frame_status = reject_reg;
            end
            else if (b != '0)
            begin
                status_res.frame_status = STATUS_TRUNCATED;
            end
            else
            begin
                status_res.frame_status = STATUS_OK;
            end
        end
        else if (reject_reg != STATUS_OK)
        begin
            status_res.frame_status = reject_reg;
        end
        else if (!(groups_done_reg || (emit_change && changes_left_reg == 8'd1)))
        begin
            status_res.frame_status = STATUS_TRUNCATED;
        end
        else
        begin
            status_res.frame_status = STATUS_OK;
        end
    end

    assign push_n = {1'b0, emit_change} + {1'b0, emit_status};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_pos_reg   <= '0;
            reject_reg       <= STATUS_OK;
            changes_left_reg <= '0;
            group_pos_reg    <= GRP_MODULE;
            held_module_reg  <= '0;
            held_param_reg   <= '0;
            held_high_reg    <= '0;
            groups_done_reg  <= 1'b0;
            wr_ptr_reg       <= '0;
            rd_ptr_reg       <= '0;
            count_reg        <= '0;
        end
        else
        begin
            header_pos_reg   <= header_pos_next;
            reject_reg       <= reject_next;
            changes_left_reg <= changes_left_next;
            group_pos_reg    <= group_pos_next;
            held_module_reg  <= held_module_next;
            held_param_reg   <= held_param_next;
            held_high_reg    <= held_high_next;
            groups_done_reg  <= groups_done_next;
            wr_ptr_reg       <= wr_ptr_reg + QPTR_W'(push_n);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + QCNT_W'(push_n) - QCNT_W'(pop);
        end
    end

    // queue payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (emit_change)
        begin
            queue_reg[wr_ptr_reg] <= change_res;
            if (emit_status)
            begin
                queue_reg[wr_ptr_reg + 1'b1] <= status_res;
            end
        end
        else if (emit_status)
        begin
            queue_reg[wr_ptr_reg] <= status_res;
        end
    end

    assign result.valid        = (count_reg != '0);
    assign result.is_status    = queue_reg[rd_ptr_reg].is_status;
    assign result.module_id    = queue_reg[rd_ptr_reg].module_id;
    assign result.param_id     = queue_reg[rd_ptr_reg].param_id;
    assign result.raw_value    = queue_reg[rd_ptr_reg].raw_value;
    assign result.frame_status = queue_reg[rd_ptr_reg].frame_status;
    assign result.last_result  = queue_reg[rd_ptr_reg].last_result;

    `ASSERT_NEVER(a_queue_no_overflow, clk, rst_n, count_reg > QCNT_W'(QUEUE_DEPTH))
    `ASSERT_PROP(a_status_is_last, clk, rst_n, result.valid && result.is_status |-> result.last_result)
    `ASSERT_PROP(a_state_cleared_after_frame, clk, rst_n, accept && body.end_of_message |=> header_pos_reg == '0 && changes_left_reg == '0 && reject_reg == STATUS_OK)
    `ASSERT_NEVER(a_no_change_in_header, clk, rst_n, emit_change && header_pos_reg < HPOS_W'(HEADER_LEN))

endmodule
